// File: rtl/core/wfsl_pkg.sv
// Shared types, constants and helpers for the wall-follow steering loop.
// No dependencies.
package wfsl_pkg;

    localparam int IR_WIDTH_DEF = 11;
    localparam int ERR_WIDE     = 24;

    localparam logic [15:0] TURN_SMALL = 16'd7620;
    localparam logic [15:0] TURN_LARGE = 16'd15604;
    localparam logic [15:0] TURN_DONE  = 16'd2521;
    localparam logic [15:0] ONE_RADIAN = 16'd10431;
    localparam logic [26:0] TURN_GAIN  = 27'd98825960;

    localparam int GAIN_P   = 33554;
    localparam int GAIN_I   = 839;
    localparam int GAIN_D   = 336;
    localparam int COF_MIN  = 503316;
    localparam int COF_MAX  = 10066330;
    localparam int Q24_ONE  = 16777216;

    localparam logic [8:0] FOLLOW_SPEED = 9'd240;
    localparam logic [8:0] WEAK_FAR     = 9'd150;
    localparam logic [8:0] WEAK_CLIFF   = 9'd75;
    localparam logic [8:0] WEAK_DOCK    = 9'd109;
    localparam logic [8:0] WEAK_EARLY   = 9'd30;
    localparam logic [8:0] WEAK_LATE_F  = 9'd112;
    localparam logic [8:0] WEAK_LATE_N  = 9'd18;

    localparam int IR_FLOOR   = 25;
    localparam int IR_CEIL    = 250;
    localparam int GOAL_FLOOR = 37;
    localparam int GOAL_RESET = 50;
    localparam int MID_LIMIT  = 100;
    localparam int MID_GAIN   = 20;
    localparam int INTEG_LIMIT = 500;
    localparam int WEAK_LIMIT  = 200;
    localparam int TICKS_LIMIT = 200;

    // ceil(2^17/3): exact floor(x/3) for x below 2^17
    localparam logic [15:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SHIFT = 17;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_STOP   = 2'd0,
        MODE_TURN   = 2'd1,
        MODE_FOLLOW = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CODE_OK      = 3'd0,
        CODE_BUMP    = 3'd1,
        CODE_CLIFF   = 3'd2,
        CODE_DOCK    = 3'd3,
        CODE_RUNNING = 3'd4
    } code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PEAK,
        ST_GOAL,
        ST_EVENT,
        ST_TURN_ERR,
        ST_TURN_MUL,
        ST_TURN_FIN,
        ST_FOL_ERR,
        ST_FOL_INT,
        ST_FOL_MUL,
        ST_FOL_SUM,
        ST_FOL_SLOW,
        ST_FOL_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic stop;
        logic peak;
        logic goal;
        logic event_apply;
        logic t_err;
        logic t_mul;
        logic t_fin;
        logic f_weak;
        logic f_err;
        logic f_int;
        logic f_mul;
        logic f_sum;
        logic f_slow;
        logic f_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       has_event;
        logic [1:0] run_mode;
        logic       weak_sig;
        logic       out_busy;
    } status_t;

    function automatic logic [15:0] aim(input logic [15:0] heading,
                                        input logic [15:0] delta,
                                        input logic        side);
        return side ? heading + delta : heading - delta;
    endfunction

endpackage

// File: rtl/core/wfsl_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on wfsl_pkg.
interface wfsl_in_if #(parameter int IR_WIDTH = wfsl_pkg::IR_WIDTH_DEF);
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic                side;
    logic [IR_WIDTH-1:0] ir_left;
    logic [IR_WIDTH-1:0] ir_right;
    logic [IR_WIDTH-1:0] ir_mid_left;
    logic [IR_WIDTH-1:0] ir_mid_right;
    logic [15:0]         heading;
    logic                bump;
    logic                cliff;
    logic                dock;
    logic                physical_bump;

    modport source (output valid, func, side, ir_left, ir_right, ir_mid_left,
                    ir_mid_right, heading, bump, cliff, dock, physical_bump,
                    input ready);
    modport sink (input valid, func, side, ir_left, ir_right, ir_mid_left,
                  ir_mid_right, heading, bump, cliff, dock, physical_bump,
                  output ready);
endinterface

interface wfsl_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] left_wheel;
    logic signed [8:0] right_wheel;
    logic [2:0]        code;
    logic [1:0]        mode;
    logic              following;

    modport source (output valid, left_wheel, right_wheel, code, mode, following,
                    input ready);
    modport sink (input valid, left_wheel, right_wheel, code, mode, following,
                  output ready);
endinterface

// File: rtl/core/wfsl_ctrl.sv
// Sequencer for the steering loop: walks one item through the datapath steps.
// Depends on wfsl_pkg.
module wfsl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wfsl_pkg::status_t  status,
    output wfsl_pkg::cmd_t     cmd
);

    wfsl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfsl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wfsl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = wfsl_pkg::ST_DISPATCH;
                end
            end
            wfsl_pkg::ST_DISPATCH:
            begin
                state_next = wfsl_pkg::ST_DONE;
                if (status.func == wfsl_pkg::FUNC_START)
                begin
                    cmd.start = 1'b1;
                end
                else if (status.func == wfsl_pkg::FUNC_STOP)
                begin
                    cmd.stop = 1'b1;
                end
                else if (status.func == wfsl_pkg::FUNC_TICK)
                begin
                    state_next = wfsl_pkg::ST_PEAK;
                end
            end
            wfsl_pkg::ST_PEAK:
            begin
                cmd.peak   = 1'b1;
                state_next = wfsl_pkg::ST_GOAL;
            end
            wfsl_pkg::ST_GOAL:
            begin
                cmd.goal   = 1'b1;
                state_next = wfsl_pkg::ST_EVENT;
            end
            wfsl_pkg::ST_EVENT:
            begin
                state_next = wfsl_pkg::ST_DONE;
                if (status.has_event)
                begin
                    cmd.event_apply = 1'b1;
                end
                else if (status.run_mode == wfsl_pkg::MODE_TURN)
                begin
                    state_next = wfsl_pkg::ST_TURN_ERR;
                end
                else if (status.run_mode == wfsl_pkg::MODE_FOLLOW)
                begin
                    state_next = wfsl_pkg::ST_FOL_ERR;
                end
            end
            wfsl_pkg::ST_TURN_ERR:
            begin
                cmd.t_err  = 1'b1;
                state_next = wfsl_pkg::ST_TURN_MUL;
            end
            wfsl_pkg::ST_TURN_MUL:
            begin
                cmd.t_mul  = 1'b1;
                state_next = wfsl_pkg::ST_TURN_FIN;
            end
            wfsl_pkg::ST_TURN_FIN:
            begin
                cmd.t_fin  = 1'b1;
                state_next = wfsl_pkg::ST_DONE;
            end
            wfsl_pkg::ST_FOL_ERR:
            begin
                if (status.weak_sig)
                begin
                    cmd.f_weak = 1'b1;
                    state_next = wfsl_pkg::ST_DONE;
                end
                else
                begin
                    cmd.f_err  = 1'b1;
                    state_next = wfsl_pkg::ST_FOL_INT;
                end
            end
            wfsl_pkg::ST_FOL_INT:
            begin
                cmd.f_int  = 1'b1;
                state_next = wfsl_pkg::ST_FOL_MUL;
            end
            wfsl_pkg::ST_FOL_MUL:
            begin
                cmd.f_mul  = 1'b1;
                state_next = wfsl_pkg::ST_FOL_SUM;
            end
            wfsl_pkg::ST_FOL_SUM:
            begin
                cmd.f_sum  = 1'b1;
                state_next = wfsl_pkg::ST_FOL_SLOW;
            end
            wfsl_pkg::ST_FOL_SLOW:
            begin
                cmd.f_slow = 1'b1;
                state_next = wfsl_pkg::ST_FOL_FIN;
            end
            wfsl_pkg::ST_FOL_FIN:
            begin
                cmd.f_fin  = 1'b1;
                state_next = wfsl_pkg::ST_DONE;
            end
            wfsl_pkg::ST_DONE:
            begin
                // wait here while the previous result is still not taken
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wfsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfsl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/wfsl_dp.sv
// Datapath of the steering loop: loop state, arithmetic, result register.
// Depends on wfsl_pkg.
module wfsl_dp #(
    parameter int IR_WIDTH = wfsl_pkg::IR_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfsl_pkg::cmd_t      cmd,
    output wfsl_pkg::status_t   status,
    input  logic [1:0]          func,
    input  logic                side,
    input  logic [IR_WIDTH-1:0] ir_left,
    input  logic [IR_WIDTH-1:0] ir_right,
    input  logic [IR_WIDTH-1:0] ir_mid_left,
    input  logic [IR_WIDTH-1:0] ir_mid_right,
    input  logic [15:0]         heading,
    input  logic                bump,
    input  logic                cliff,
    input  logic                dock,
    input  logic                physical_bump,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [8:0]   left_wheel,
    output logic signed [8:0]   right_wheel,
    output logic [2:0]          code,
    output logic [1:0]          mode,
    output logic                following
);

    localparam int QW = IR_WIDTH + 2;
    localparam int EW = wfsl_pkg::ERR_WIDE;

    // latched item
    logic [1:0]          func_reg;
    logic                side_reg;
    logic [IR_WIDTH-1:0] irl_reg, irr_reg, mdl_reg, mdr_reg;
    logic [15:0]         heading_reg;
    logic                bump_reg, cliff_reg, dock_reg, phys_reg;

    // loop state
    logic [1:0]          run_mode_reg, run_mode_next;
    logic                wall_side_reg, wall_side_next;
    logic [15:0]         goal_heading_reg, goal_heading_next;
    logic [8:0]          ir_goal_reg, ir_goal_next;
    logic [IR_WIDTH-1:0] ir_peak_reg, ir_peak_next;
    logic signed [9:0]   integ_reg, integ_next;
    logic signed [15:0]  prev_err_reg, prev_err_next;
    logic [7:0]          follow_ticks_reg, follow_ticks_next;
    logic [7:0]          weak_ticks_reg, weak_ticks_next;
    logic [1:0]          avoid_reg, avoid_next;
    logic signed [8:0]   left_cmd_reg, left_cmd_next;
    logic signed [8:0]   right_cmd_reg, right_cmd_next;
    logic                follow_reg, follow_next;
    logic [2:0]          code_reg, code_next;

    // working registers
    logic signed [15:0]  t_err_reg, t_err_next;
    logic [15:0]         t_mag_reg, t_mag_next;
    logic [8:0]          t_spd_reg, t_spd_next;
    logic signed [15:0]  e_reg, e_next;
    logic signed [31:0]  pp_reg, pp_next, pi_reg, pi_next, pd_reg, pd_next;
    logic [23:0]         cof_reg, cof_next;
    logic [7:0]          slow_reg, slow_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic signed [8:0]   out_left_reg, out_right_reg;
    logic [2:0]          out_code_reg;
    logic [1:0]          out_mode_reg;
    logic                out_follow_reg;

    // combinational helpers
    logic [IR_WIDTH-1:0] v_now, mid_now;
    logic [QW-1:0]       q_in;
    logic [QW+15:0]      q_prod;
    logic [QW-2:0]       tgt;
    logic [8:0]          mid_thr;
    logic signed [EW-1:0] e_wide;
    logic signed [17:0]  i_sum;
    logic [15:0]         t_diff;
    logic [40:0]         t_prod;
    logic signed [31:0]  c_sum, c_abs;
    logic [31:0]         s_prod;
    logic [8:0]          near_w, far_w, slow9;

    assign v_now   = wall_side_reg ? irr_reg : irl_reg;
    assign mid_now = wall_side_reg ? mdr_reg : mdl_reg;

    always_comb
    begin
        status.func      = func_reg;
        status.has_event = bump_reg | cliff_reg | dock_reg;
        status.run_mode  = run_mode_reg;
        status.weak_sig  = (32'(v_now) < wfsl_pkg::IR_FLOOR);
        status.out_busy  = out_valid_reg & ~out_ready;
    end

    // target level: peak/3 or (5*peak >> 1)/3 through one reciprocal multiply
    always_comb
    begin
        if (phys_reg)
        begin
            q_in = QW'(ir_peak_reg);
        end
        else
        begin
            q_in = QW'(((QW+1)'(ir_peak_reg) << 2) + (QW+1)'(ir_peak_reg) >> 1);
        end
        q_prod = (QW+16)'(q_in) * (QW+16)'(wfsl_pkg::DIV3_MUL);
        tgt    = q_prod[QW+15:wfsl_pkg::DIV3_SHIFT];
    end

    assign mid_thr = 9'((wfsl_pkg::MID_LIMIT + 32'(ir_goal_reg)) >> 1);
    assign t_diff  = goal_heading_reg - heading_reg;
    assign t_prod  = 41'(t_mag_reg[13:0]) * 41'(wfsl_pkg::TURN_GAIN);
    assign slow9   = {1'b0, slow_reg};

    always_comb
    begin
        e_wide = EW'(v_now) - EW'(ir_goal_reg);
        if (32'(mid_now) > 32'(mid_thr))
        begin
            e_wide = e_wide + (EW'(mid_now) << 4) + (EW'(mid_now) << 2);
        end
        i_sum  = 18'(integ_reg) + 18'(e_reg);
        c_sum  = pp_reg + pi_reg - pd_reg;
        c_abs  = (c_sum < 0) ? -c_sum : c_sum;
        s_prod = 32'(wfsl_pkg::Q24_ONE - 32'(cof_reg)) * 32'(wfsl_pkg::FOLLOW_SPEED);
    end

    always_comb
    begin
        run_mode_next     = run_mode_reg;
        wall_side_next    = wall_side_reg;
        goal_heading_next = goal_heading_reg;
        ir_goal_next      = ir_goal_reg;
        ir_peak_next      = ir_peak_reg;
        integ_next        = integ_reg;
        prev_err_next     = prev_err_reg;
        follow_ticks_next = follow_ticks_reg;
        weak_ticks_next   = weak_ticks_reg;
        avoid_next        = avoid_reg;
        left_cmd_next     = left_cmd_reg;
        right_cmd_next    = right_cmd_reg;
        follow_next       = follow_reg;
        code_next         = code_reg;
        t_err_next        = t_err_reg;
        t_mag_next        = t_mag_reg;
        t_spd_next        = t_spd_reg;
        e_next            = e_reg;
        pp_next           = pp_reg;
        pi_next           = pi_reg;
        pd_next           = pd_reg;
        cof_next          = cof_reg;
        slow_next         = slow_reg;
        near_w            = wfsl_pkg::FOLLOW_SPEED;
        far_w             = wfsl_pkg::FOLLOW_SPEED;

        if (cmd.load)
        begin
            code_next = wfsl_pkg::CODE_OK;
        end

        if (cmd.start)
        begin
            if (run_mode_reg != wfsl_pkg::MODE_STOP && wall_side_reg == side_reg)
            begin
                code_next = wfsl_pkg::CODE_RUNNING;
            end
            else
            begin
                run_mode_next     = wfsl_pkg::MODE_TURN;
                wall_side_next    = side_reg;
                goal_heading_next = wfsl_pkg::aim(heading_reg, wfsl_pkg::TURN_SMALL,
                                                  side_reg);
                ir_goal_next      = 9'(wfsl_pkg::GOAL_RESET);
                ir_peak_next      = '0;
                follow_next       = 1'b0;
            end
        end

        if (cmd.stop)
        begin
            run_mode_next = wfsl_pkg::MODE_STOP;
        end

        if (cmd.peak && ir_peak_reg < v_now)
        begin
            ir_peak_next = v_now;
        end

        if (cmd.goal)
        begin
            if (32'(tgt) < wfsl_pkg::GOAL_FLOOR)
            begin
                ir_goal_next = 9'(wfsl_pkg::GOAL_FLOOR);
            end
            else if (32'(tgt) > wfsl_pkg::IR_CEIL)
            begin
                ir_goal_next = 9'(wfsl_pkg::IR_CEIL);
            end
            else
            begin
                ir_goal_next = 9'(tgt);
            end
        end

        if (cmd.event_apply)
        begin
            run_mode_next = wfsl_pkg::MODE_TURN;
            ir_peak_next  = ir_peak_reg >> 2;
            ir_goal_next  = ir_goal_reg >> 2;
            follow_next   = 1'b0;
            if (cliff_reg)
            begin
                code_next         = wfsl_pkg::CODE_CLIFF;
                avoid_next        = avoid_reg | 2'b01;
                goal_heading_next = wfsl_pkg::aim(heading_reg, wfsl_pkg::TURN_SMALL,
                                                  wall_side_reg);
            end
            else if (bump_reg)
            begin
                code_next         = wfsl_pkg::CODE_BUMP;
                goal_heading_next = wfsl_pkg::aim(heading_reg, wfsl_pkg::TURN_SMALL,
                                                  wall_side_reg);
            end
            else
            begin
                code_next         = wfsl_pkg::CODE_DOCK;
                avoid_next        = avoid_reg | 2'b10;
                goal_heading_next = wfsl_pkg::aim(heading_reg, wfsl_pkg::TURN_LARGE,
                                                  wall_side_reg);
            end
        end

        if (cmd.t_err)
        begin
            t_err_next      = t_diff;
            t_mag_next      = t_diff[15] ? 16'(16'd0 - t_diff) : t_diff;
            weak_ticks_next = '0;
        end

        if (cmd.t_mul)
        begin
            t_spd_next = (t_mag_reg >= wfsl_pkg::ONE_RADIAN) ? wfsl_pkg::FOLLOW_SPEED
                                                             : t_prod[40:32];
        end

        if (cmd.t_fin)
        begin
            if (t_mag_reg < wfsl_pkg::TURN_DONE)
            begin
                left_cmd_next  = '0;
                right_cmd_next = '0;
                run_mode_next  = wfsl_pkg::MODE_FOLLOW;
            end
            else if (t_err_reg < 0)
            begin
                left_cmd_next  = t_spd_reg;
                right_cmd_next = -t_spd_reg;
            end
            else
            begin
                left_cmd_next  = -t_spd_reg;
                right_cmd_next = t_spd_reg;
            end
        end

        if (cmd.f_weak)
        begin
            far_w = wfsl_pkg::WEAK_FAR;
            if (avoid_reg[0])
            begin
                near_w = wfsl_pkg::WEAK_CLIFF;
            end
            else if (avoid_reg[1])
            begin
                near_w = wfsl_pkg::WEAK_DOCK;
            end
            else if (32'(weak_ticks_reg) < wfsl_pkg::WEAK_LIMIT)
            begin
                near_w = wfsl_pkg::WEAK_EARLY;
            end
            else
            begin
                far_w  = wfsl_pkg::WEAK_LATE_F;
                near_w = wfsl_pkg::WEAK_LATE_N;
            end
            integ_next        = '0;
            follow_ticks_next = '0;
            prev_err_next     = '0;
            if (32'(weak_ticks_reg) < wfsl_pkg::WEAK_LIMIT)
            begin
                weak_ticks_next = weak_ticks_reg + 8'd1;
            end
            else
            begin
                weak_ticks_next = 8'(wfsl_pkg::WEAK_LIMIT);
            end
        end

        if (cmd.f_err)
        begin
            if (e_wide > EW'(32767))
            begin
                e_next = 16'sh7FFF;
            end
            else if (e_wide < -EW'(32768))
            begin
                e_next = -16'sh8000;
            end
            else
            begin
                e_next = 16'(e_wide);
            end
            if (32'(follow_ticks_reg) < wfsl_pkg::TICKS_LIMIT)
            begin
                follow_ticks_next = follow_ticks_reg + 8'd1;
            end
            else
            begin
                follow_ticks_next = 8'(wfsl_pkg::TICKS_LIMIT);
            end
        end

        if (cmd.f_int)
        begin
            if (i_sum > 18'(wfsl_pkg::INTEG_LIMIT))
            begin
                integ_next = 10'(wfsl_pkg::INTEG_LIMIT);
            end
            else if (i_sum < -18'(wfsl_pkg::INTEG_LIMIT))
            begin
                integ_next = -10'(wfsl_pkg::INTEG_LIMIT);
            end
            else
            begin
                integ_next = 10'(i_sum);
            end
        end

        if (cmd.f_mul)
        begin
            pp_next = 32'(e_reg) * 32'(wfsl_pkg::GAIN_P);
            pi_next = 32'(integ_reg) * 32'(wfsl_pkg::GAIN_I);
            pd_next = (32'(e_reg) - 32'(prev_err_reg)) * 32'(wfsl_pkg::GAIN_D);
        end

        if (cmd.f_sum)
        begin
            if (c_abs > wfsl_pkg::COF_MAX)
            begin
                cof_next = 24'(wfsl_pkg::COF_MAX);
            end
            else if (c_abs < wfsl_pkg::COF_MIN)
            begin
                cof_next = 24'(wfsl_pkg::COF_MIN);
            end
            else
            begin
                cof_next = 24'(c_abs);
            end
        end

        if (cmd.f_slow)
        begin
            slow_next = s_prod[31:24];
        end

        if (cmd.f_fin)
        begin
            if (e_reg > 0)
            begin
                far_w = slow9;
            end
            else if (e_reg < 0)
            begin
                near_w = slow9;
            end
            // soft start for the first ticks of following
            if (32'(follow_ticks_reg) < wfsl_pkg::TICKS_LIMIT - 1)
            begin
                far_w  = far_w >> 1;
                near_w = near_w >> 1;
            end
            follow_next   = 1'b1;
            avoid_next    = '0;
            weak_ticks_next = '0;
            prev_err_next = e_reg;
        end

        if (cmd.f_weak || cmd.f_fin)
        begin
            if (wall_side_reg)
            begin
                right_cmd_next = near_w;
                left_cmd_next  = far_w;
            end
            else
            begin
                left_cmd_next  = near_w;
                right_cmd_next = far_w;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg     <= wfsl_pkg::MODE_STOP;
            wall_side_reg    <= 1'b0;
            goal_heading_reg <= '0;
            ir_goal_reg      <= 9'(wfsl_pkg::GOAL_RESET);
            ir_peak_reg      <= '0;
            integ_reg        <= '0;
            prev_err_reg     <= '0;
            follow_ticks_reg <= '0;
            weak_ticks_reg   <= '0;
            avoid_reg        <= '0;
            left_cmd_reg     <= '0;
            right_cmd_reg    <= '0;
            follow_reg       <= 1'b0;
            code_reg         <= wfsl_pkg::CODE_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            run_mode_reg     <= run_mode_next;
            wall_side_reg    <= wall_side_next;
            goal_heading_reg <= goal_heading_next;
            ir_goal_reg      <= ir_goal_next;
            ir_peak_reg      <= ir_peak_next;
            integ_reg        <= integ_next;
            prev_err_reg     <= prev_err_next;
            follow_ticks_reg <= follow_ticks_next;
            weak_ticks_reg   <= weak_ticks_next;
            avoid_reg        <= avoid_next;
            left_cmd_reg     <= left_cmd_next;
            right_cmd_reg    <= right_cmd_next;
            follow_reg       <= follow_next;
            code_reg         <= code_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            side_reg    <= side;
            irl_reg     <= ir_left;
            irr_reg     <= ir_right;
            mdl_reg     <= ir_mid_left;
            mdr_reg     <= ir_mid_right;
            heading_reg <= heading;
            bump_reg    <= bump;
            cliff_reg   <= cliff;
            dock_reg    <= dock;
            phys_reg    <= physical_bump;
        end
        t_err_reg <= t_err_next;
        t_mag_reg <= t_mag_next;
        t_spd_reg <= t_spd_next;
        e_reg     <= e_next;
        pp_reg    <= pp_next;
        pi_reg    <= pi_next;
        pd_reg    <= pd_next;
        cof_reg   <= cof_next;
        slow_reg  <= slow_next;
        if (cmd.out_load)
        begin
            out_left_reg   <= left_cmd_reg;
            out_right_reg  <= right_cmd_reg;
            out_code_reg   <= code_reg;
            out_mode_reg   <= run_mode_reg;
            out_follow_reg <= follow_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_wheel  = out_left_reg;
    assign right_wheel = out_right_reg;
    assign code        = out_code_reg;
    assign mode        = out_mode_reg;
    assign following   = out_follow_reg;

endmodule

// File: rtl/core/wall_follow_steering_loop.sv
// Top level of the wall-follow steering loop: sequencer plus datapath.
// Depends on wfsl_pkg, wfsl_if, wfsl_ctrl and wfsl_dp.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  in_ch    | in  | func, side, four IR levels, heading, bump, cliff, dock, phys
//  out_ch   | out | left_wheel, right_wheel, code, mode, following
//
// One item at a time. Start, stop and unused items are only dispatched; ticks
// also update the peak and goal levels, then apply an event, or else run the
// turning steps or the following steps (fewer when the wall is weak) if not
// stopped, set by the sequencer stepping through the multiply and clamp stages.
// A result register holds the last result; the next item is taken while it
// waits and stalls only in its final step. Reset is asynchronous, active low.
module wall_follow_steering_loop #(
    parameter int IR_WIDTH = wfsl_pkg::IR_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    wfsl_in_if.sink     in_ch,
    wfsl_out_if.source  out_ch
);

    wfsl_pkg::cmd_t    cmd;
    wfsl_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;

    wfsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wfsl_dp #(
        .IR_WIDTH (IR_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (in_ch.func),
        .side          (in_ch.side),
        .ir_left       (in_ch.ir_left),
        .ir_right      (in_ch.ir_right),
        .ir_mid_left   (in_ch.ir_mid_left),
        .ir_mid_right  (in_ch.ir_mid_right),
        .heading       (in_ch.heading),
        .bump          (in_ch.bump),
        .cliff         (in_ch.cliff),
        .dock          (in_ch.dock),
        .physical_bump (in_ch.physical_bump),
        .out_valid     (out_valid),
        .out_ready     (out_ch.ready),
        .left_wheel    (out_ch.left_wheel),
        .right_wheel   (out_ch.right_wheel),
        .code          (out_ch.code),
        .mode          (out_ch.mode),
        .following     (out_ch.following)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

endmodule
